// File: hw/rtl/mi3_pkg.sv
// Shared types, widths and constants for the 3x3 matrix inverse unit.
package mi3_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADJ_W         = 2 * WORD_BITS;   // cofactor magnitude
    localparam int DET_W         = 3 * WORD_BITS;   // determinant magnitude
    localparam int QB            = WORD_BITS + 1;   // quotient bits per divide
    localparam int N_ELEM        = 9;
    localparam int IN_DATA_W     = ((N_ELEM * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W    = (((N_ELEM + 1) * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W    = 2;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic             neg;
        logic [ADJ_W-1:0] mag;
    } adj_t;

    typedef struct packed {
        logic             neg;
        logic [DET_W-1:0] mag;
    } det_t;

    typedef struct packed {
        logic                              saturated;
        logic                              singular;
        logic [WORD_BITS-1:0]              det;
        logic [N_ELEM-1:0][WORD_BITS-1:0]  inv;
    } res_t;

endpackage

// File: hw/rtl/mi3_cofactor.sv
// One cofactor lane: two products and their difference, in sign-magnitude.
module mi3_cofactor
(
    input  logic          clk,
    input  logic          adv,
    input  mi3_pkg::word_t a,
    input  mi3_pkg::word_t b,
    input  mi3_pkg::word_t c,
    input  mi3_pkg::word_t d,
    output mi3_pkg::adj_t  res
);
    import mi3_pkg::*;

    logic signed [2*WORD_BITS-1:0] p0_reg, p1_reg;
    logic signed [2*WORD_BITS:0]   diff;
    logic        [2*WORD_BITS:0]   diff_abs;
    adj_t                          res_reg;

    assign diff     = {p0_reg[2*WORD_BITS-1], p0_reg} - {p1_reg[2*WORD_BITS-1], p1_reg};
    assign diff_abs = diff[2*WORD_BITS] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg      <= a * b;
            p1_reg      <= c * d;
            res_reg.neg <= diff[2*WORD_BITS];
            res_reg.mag <= diff_abs[ADJ_W-1:0];
        end
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/mi3_det.sv
// Determinant from the first column and its cofactors, split 32x32 products.
module mi3_det
(
    input  logic           clk,
    input  logic           adv,
    input  mi3_pkg::word_t e [3],
    input  mi3_pkg::adj_t  f [3],
    output mi3_pkg::det_t  det
);
    import mi3_pkg::*;

    localparam int SW = DET_W + 2;

    logic [2*WORD_BITS-1:0] lo_reg [3];
    logic [2*WORD_BITS-1:0] hi_reg [3];
    logic                   sgn_reg [3];
    logic signed [SW-1:0]   sum_reg;
    logic signed [SW-1:0]   sum_next;
    logic        [SW-1:0]   sum_abs;
    det_t                   det_reg;
    logic [WORD_BITS-1:0]   am [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            am[i] = e[i][WORD_BITS-1] ? (~e[i] + 1'b1) : e[i];
        end
    end

    always_comb
    begin
        logic [DET_W-1:0] term;
        sum_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            term = {{WORD_BITS{1'b0}}, lo_reg[i]} + {hi_reg[i], {WORD_BITS{1'b0}}};
            if (sgn_reg[i])
                sum_next = sum_next - $signed({2'b00, term});
            else
                sum_next = sum_next + $signed({2'b00, term});
        end
    end

    assign sum_abs = sum_reg[SW-1] ? (~sum_reg + 1'b1) : sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i]  <= am[i] * f[i].mag[WORD_BITS-1:0];
                hi_reg[i]  <= am[i] * f[i].mag[ADJ_W-1:WORD_BITS];
                sgn_reg[i] <= e[i][WORD_BITS-1] ^ f[i].neg;
            end
            sum_reg     <= sum_next;
            det_reg.neg <= sum_reg[SW-1];
            det_reg.mag <= sum_abs[DET_W-1:0];
        end
    end

    assign det = det_reg;

endmodule

// File: hw/rtl/mi3_div.sv
// Pipelined restoring divider lane: round(cofactor * 2^(2F) / det), saturated.
module mi3_div
#(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
)
(
    input  logic           clk,
    input  logic           adv,
    input  mi3_pkg::adj_t  num,
    input  mi3_pkg::det_t  den,
    output mi3_pkg::word_t q,
    output logic           sat
);
    import mi3_pkg::*;

    localparam int RW = DET_W + QB;
    localparam logic [QB:0] MAXPOS = (QB+1)'((65'd1 << (WORD_BITS - 1)) - 65'd1);

    logic [RW-1:0]    rem_reg [QB+1];
    logic [DET_W-1:0] d_reg   [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             neg_reg [QB+1];
    logic             ovf_reg [QB+1];
    logic [RW-1:0]    n_ext;
    logic [RW:0]      rem2;
    logic             rnd;
    logic [QB:0]      qr;
    logic [QB:0]      lim;
    logic             sat_c;
    logic [QB:0]      mag;
    logic [WORD_BITS-1:0] mag_w;
    word_t            q_reg_out;
    logic             sat_reg;

    assign n_ext = RW'(num.mag) << (2 * FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= n_ext;
            d_reg[0]   <= den.mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= num.neg ^ den.neg;
            ovf_reg[0] <= n_ext >= (RW'(den.mag) << QB);
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        localparam int B = QB - k;
        logic [RW-1:0] dsh;
        logic          take;
        assign dsh  = RW'(d_reg[k-1]) << B;
        assign take = rem_reg[k-1] >= dsh;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= take ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (take ? (QB'(1) << B) : '0);
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    // round half away from zero on the magnitude, then clamp
    assign rem2  = {rem_reg[QB], 1'b0};
    assign rnd   = rem2 >= (RW+1)'(d_reg[QB]);
    assign qr    = {1'b0, q_reg[QB]} + {{QB{1'b0}}, rnd};
    assign lim   = MAXPOS + {{QB{1'b0}}, neg_reg[QB]};
    assign sat_c = ovf_reg[QB] || (qr > lim);
    assign mag   = sat_c ? lim : qr;
    assign mag_w = mag[WORD_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg_out <= neg_reg[QB] ? $signed(~mag_w + 1'b1) : $signed(mag_w);
            sat_reg   <= sat_c;
        end
    end

    assign q   = q_reg_out;
    assign sat = sat_reg;

endmodule

// File: hw/rtl/mi3_merge.sv
// Merge stage: round and clamp the determinant, fold lane flags, zero if singular.
module mi3_merge
#(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
)
(
    input  logic           clk,
    input  logic           adv,
    input  mi3_pkg::det_t  det,
    input  mi3_pkg::word_t inv [9],
    input  logic           sat [9],
    output mi3_pkg::res_t  res
);
    import mi3_pkg::*;

    localparam logic [DET_W:0] MAXPOS = (DET_W+1)'((65'd1 << (WORD_BITS - 1)) - 65'd1);

    logic [DET_W:0]       rsum;
    logic [DET_W:0]       dq;
    logic [DET_W:0]       lim;
    logic                 dsat;
    logic [DET_W:0]       dmag;
    logic [WORD_BITS-1:0] dmag_w;
    logic                 singular;
    logic                 any_sat;
    res_t                 res_reg;

    assign singular = (det.mag == '0);
    assign rsum     = {1'b0, det.mag} + ((DET_W+1)'(1) << (2 * FRAC_BITS - 1));
    assign dq       = rsum >> (2 * FRAC_BITS);
    assign lim      = MAXPOS + {{DET_W{1'b0}}, det.neg};
    assign dsat     = dq > lim;
    assign dmag     = dsat ? lim : dq;
    assign dmag_w   = dmag[WORD_BITS-1:0];

    always_comb
    begin
        any_sat = dsat;
        for (int i = 0; i < 9; i++)
        begin
            any_sat = any_sat | sat[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.singular  <= singular;
            res_reg.saturated <= !singular && any_sat;
            res_reg.det       <= singular ? '0 : (det.neg ? (~dmag_w + 1'b1) : dmag_w);
            for (int i = 0; i < 9; i++)
            begin
                res_reg.inv[i] <= singular ? '0 : inv[i];
            end
        end
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/matrix_inverse_3x3_unit.sv
// Top level of the 3x3 fixed-point matrix inverse unit (adjugate method).
//
// Usage: one request on the s_ channel carries a whole 3x3 matrix of signed
// Q16.16 entries; one request on the m_ channel returns the nine inverse
// entries, the rounded determinant and two flags (singular, saturated).
// The unit is fully pipelined: a new matrix is taken every cycle while the
// output side keeps up. A request passes through the cofactor lanes, the
// determinant, the divider lanes (one quotient bit per stage), the merge
// stage and the output queue. The whole pipeline moves in lockstep and
// drains into a two-entry output queue; s_tready drops only when that
// queue is full, so a stalled receiver still lets the queue fill before
// input is held. When m_tready is low the queued results hold in place,
// none is lost.
// Reset clears the valid bits of every stage and empties the output queue;
// datapath registers are not reset.
module matrix_inverse_3x3_unit
#(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0 .. in_r2_c2 (32 bits each)
    input  logic [mi3_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // inv_r0_c0 .. inv_r2_c2 (32 bits each), determinant (32 bits)
    output logic [mi3_pkg::OUT_DATA_W-1:0]    m_tdata,
    // singular, saturated
    output logic [mi3_pkg::OUT_USER_W-1:0]    m_tuser
);
    import mi3_pkg::*;

    localparam int DIV_LAT = QB + 2;
    localparam int PIPE_LEN = 5 + DIV_LAT + 1;

    logic                adv;
    logic [PIPE_LEN-1:0] v_reg;
    word_t               a [9];
    word_t               a_d_reg [2][9];
    adj_t                adj [9];
    adj_t                adj_d_reg [3][9];
    det_t                det;
    det_t                det_d_reg [DIV_LAT];
    word_t               det_col [3];
    adj_t                adj_row [3];
    word_t               inv [9];
    logic                lane_sat [9];
    res_t                res;

    res_t                q_mem [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic                push, pop;

    // advance the whole pipe unless the output queue is full
    assign adv      = (cnt_reg != 2'd2);
    assign s_tready = adv;

    for (genvar k = 0; k < 9; k++)
    begin : g_in
        assign a[k] = s_tdata[k*WORD_BITS +: WORD_BITS];
    end

    // cofactor lanes: adj[r][c] from the transposed 2x2 minor
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int IA = ((c + 1) % 3) * 3 + (r + 1) % 3;
            localparam int IB = ((c + 2) % 3) * 3 + (r + 2) % 3;
            localparam int IC = ((c + 1) % 3) * 3 + (r + 2) % 3;
            localparam int ID = ((c + 2) % 3) * 3 + (r + 1) % 3;
            mi3_cofactor u_cof
            (
                .clk (clk),
                .adv (adv),
                .a   (a[IA]),
                .b   (a[IB]),
                .c   (a[IC]),
                .d   (a[ID]),
                .res (adj[r*3+c])
            );
        end
    end

    // hold the first column for the determinant, the cofactors for the dividers and the determinant for the merge stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_d_reg[0] <= a;
            a_d_reg[1] <= a_d_reg[0];
            adj_d_reg[0] <= adj;
            adj_d_reg[1] <= adj_d_reg[0];
            adj_d_reg[2] <= adj_d_reg[1];
            det_d_reg[0] <= det;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                det_d_reg[i] <= det_d_reg[i-1];
            end
        end
    end

    assign det_col[0] = a_d_reg[1][0];
    assign det_col[1] = a_d_reg[1][3];
    assign det_col[2] = a_d_reg[1][6];
    assign adj_row[0] = adj[0];
    assign adj_row[1] = adj[1];
    assign adj_row[2] = adj[2];

    mi3_det u_det
    (
        .clk (clk),
        .adv (adv),
        .e   (det_col),
        .f   (adj_row),
        .det (det)
    );

    for (genvar k = 0; k < 9; k++)
    begin : g_div
        mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div
        (
            .clk (clk),
            .adv (adv),
            .num (adj_d_reg[2][k]),
            .den (det),
            .q   (inv[k]),
            .sat (lane_sat[k])
        );
    end

    mi3_merge #(.FRAC_BITS(FRAC_BITS)) u_merge
    (
        .clk (clk),
        .adv (adv),
        .det (det_d_reg[DIV_LAT-1]),
        .inv (inv),
        .sat (lane_sat),
        .res (res)
    );

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[PIPE_LEN-2:0], s_tvalid};
        end
    end

    // two-entry output queue
    assign push = adv && v_reg[PIPE_LEN-1];
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = OUT_DATA_W'({q_mem[rd_ptr_reg].det, q_mem[rd_ptr_reg].inv});
    assign m_tuser  = {q_mem[rd_ptr_reg].saturated, q_mem[rd_ptr_reg].singular};

endmodule
